@@ src/bpfl_pkg.sv @@
// Shared types and constants for the block pool free-list allocator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package bpfl_pkg;

    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 32;
    localparam int BLK_W    = 12;
    localparam int BYTES_W  = 16;
    localparam int CHUNK_W  = 13;
    localparam int STAT_W   = 2;
    localparam int TALLY_W  = 32;
    localparam int BTALLY_W = 40;
    localparam int LINK_W   = BLK_W + 1;    // link plus "list continues" bit
    localparam int INDEX_LIMIT = 1 << BLK_W; // indices the request field can name

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESIZE = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TOO_BIG   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd2;

    // Configuration register indexes
    localparam logic CFG_BLOCK_BYTES  = 1'b0;
    localparam logic CFG_CHUNK_BLOCKS = 1'b1;

    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST  = 16'd256;
    localparam logic [CHUNK_W-1:0] CHUNK_BLOCKS_RST = 13'd1024;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming request
        logic commit;   // apply the request and load the result register
    } bpfl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_room; // result register empty or being drained this cycle
    } bpfl_stat_t;

endpackage

`default_nettype wire

@@ src/bpfl_ctrl.sv @@
// Request sequencer: one-hot state machine, capture then execute.
// Depends on bpfl_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module bpfl_ctrl
    import bpfl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire bpfl_stat_t stat,
    output bpfl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        in_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // wait here while the previous result is still unclaimed
                cmd.commit = stat.out_room;
                if (stat.out_room)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ src/bpfl_datapath.sv @@
// Allocator datapath: request latch, link store, free-list head, fresh counter,
// tallies and result register. Depends on bpfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpfl_datapath
    import bpfl_pkg::*;
#(
    parameter int POOL_BLOCKS = 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bpfl_cmd_t             cmd,
    output bpfl_stat_t                 stat,
    input  wire logic                  cfg_write,
    input  wire logic                  cfg_index,
    input  wire logic [BYTES_W-1:0]    cfg_data,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [SIZE_W-1:0]     request_size,
    input  wire logic                  has_block,
    input  wire logic [BLK_W-1:0]      block_index,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STAT_W-1:0]          status,
    output logic                       gives_block,
    output logic [BLK_W-1:0]           result_block,
    output logic [TALLY_W-1:0]         allocations_done,
    output logic [TALLY_W-1:0]         frees_done,
    output logic [BTALLY_W-1:0]        bytes_in_use,
    output logic [CHUNK_W-1:0]         chunks_grown
);

    localparam int STORE_DEPTH = (POOL_BLOCKS < INDEX_LIMIT) ? POOL_BLOCKS : INDEX_LIMIT;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(POOL_BLOCKS + 1);
    localparam int SW = ((FW > CHUNK_W) ? FW : CHUNK_W) + 1;

    // configuration
    logic [BYTES_W-1:0]  block_bytes_reg;
    logic [CHUNK_W-1:0]  chunk_blocks_reg;

    // latched request
    logic [KIND_W-1:0]   kind_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic                has_reg;
    logic [BLK_W-1:0]    idx_reg;

    // allocator state
    logic [BLK_W-1:0]    head_reg, head_next;
    logic                nonempty_reg, nonempty_next;
    logic [FW-1:0]       fresh_next_reg, fresh_next_next;
    logic [CHUNK_W-1:0]  fresh_left_reg, fresh_left_next;
    logic [CHUNK_W-1:0]  chunk_tally_reg, chunk_tally_next;
    logic [TALLY_W-1:0]  alloc_tally_reg, alloc_tally_next;
    logic [TALLY_W-1:0]  free_tally_reg, free_tally_next;
    logic [BTALLY_W-1:0] byte_tally_reg, byte_tally_next;

    // link store
    logic [LINK_W-1:0]   link_mem [STORE_DEPTH];
    logic [LINK_W-1:0]   link_rd_reg;
    logic                link_we;

    // result register
    logic                out_valid_reg;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic                gives_reg, gives_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;

    logic                size_ok;
    logic [CHUNK_W-1:0]  chunk_eff;
    logic                grow_fits;
    logic                free_hit;

    assign size_ok   = size_reg <= SIZE_W'(block_bytes_reg);
    assign chunk_eff = (chunk_blocks_reg == '0) ? CHUNK_W'(1) : chunk_blocks_reg;
    assign grow_fits = (SW'(fresh_next_reg) + SW'(chunk_eff)) <= SW'(POOL_BLOCKS);
    assign free_hit  = has_reg && (SW'(idx_reg) < SW'(POOL_BLOCKS));

    assign stat.out_room = !out_valid_reg || !out_stall;

    always_comb
    begin
        head_next        = head_reg;
        nonempty_next    = nonempty_reg;
        fresh_next_next  = fresh_next_reg;
        fresh_left_next  = fresh_left_reg;
        chunk_tally_next = chunk_tally_reg;
        alloc_tally_next = alloc_tally_reg;
        free_tally_next  = free_tally_reg;
        byte_tally_next  = byte_tally_reg;
        status_next      = STAT_OK;
        gives_next       = 1'b0;
        blk_next         = '0;
        link_we          = 1'b0;
        unique case (kind_reg)
            KIND_ALLOC:
            begin
                priority if (!size_ok)
                begin
                    status_next = STAT_TOO_BIG;
                end
                else if (nonempty_reg)
                begin
                    gives_next    = 1'b1;
                    blk_next      = head_reg;
                    head_next     = link_rd_reg[BLK_W-1:0];
                    nonempty_next = link_rd_reg[BLK_W];
                end
                else if (fresh_left_reg != '0)
                begin
                    gives_next      = 1'b1;
                    blk_next        = BLK_W'(fresh_next_reg);
                    fresh_next_next = fresh_next_reg + FW'(1);
                    fresh_left_next = fresh_left_reg - CHUNK_W'(1);
                end
                else if (grow_fits)
                begin
                    gives_next       = 1'b1;
                    blk_next         = BLK_W'(fresh_next_reg);
                    fresh_next_next  = fresh_next_reg + FW'(1);
                    fresh_left_next  = chunk_eff - CHUNK_W'(1);
                    chunk_tally_next = chunk_tally_reg + CHUNK_W'(1);
                end
                else
                begin
                    status_next = STAT_EXHAUSTED;
                end
                if (gives_next)
                begin
                    alloc_tally_next = alloc_tally_reg + TALLY_W'(1);
                    byte_tally_next  = byte_tally_reg + BTALLY_W'(block_bytes_reg);
                end
            end
            KIND_FREE:
            begin
                if (free_hit)
                begin
                    link_we         = 1'b1;
                    head_next       = idx_reg;
                    nonempty_next   = 1'b1;
                    free_tally_next = free_tally_reg + TALLY_W'(1);
                    byte_tally_next = byte_tally_reg - BTALLY_W'(block_bytes_reg);
                end
            end
            KIND_RESIZE:
            begin
                if (size_ok)
                begin
                    gives_next = has_reg;
                    blk_next   = has_reg ? idx_reg : '0;
                end
                else
                begin
                    status_next = STAT_TOO_BIG;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    // link store: one write, one registered read of the current head
    always_ff @(posedge clk)
    begin
        if (cmd.commit && link_we)
        begin
            link_mem[idx_reg[AW-1:0]] <= {nonempty_reg, head_reg};
        end
        link_rd_reg <= link_mem[head_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            size_reg <= request_size;
            has_reg  <= has_block;
            idx_reg  <= block_index;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            gives_reg  <= gives_next;
            blk_reg    <= blk_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg  <= BLOCK_BYTES_RST;
            chunk_blocks_reg <= CHUNK_BLOCKS_RST;
            head_reg         <= '0;
            nonempty_reg     <= 1'b0;
            fresh_next_reg   <= '0;
            fresh_left_reg   <= '0;
            chunk_tally_reg  <= '0;
            alloc_tally_reg  <= '0;
            free_tally_reg   <= '0;
            byte_tally_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_BLOCK_BYTES:  block_bytes_reg  <= cfg_data;
                    CFG_CHUNK_BLOCKS: chunk_blocks_reg <= cfg_data[CHUNK_W-1:0];
                    default:          block_bytes_reg  <= block_bytes_reg;
                endcase
            end
            if (cmd.commit)
            begin
                head_reg        <= head_next;
                nonempty_reg    <= nonempty_next;
                fresh_next_reg  <= fresh_next_next;
                fresh_left_reg  <= fresh_left_next;
                chunk_tally_reg <= chunk_tally_next;
                alloc_tally_reg <= alloc_tally_next;
                free_tally_reg  <= free_tally_next;
                byte_tally_reg  <= byte_tally_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Tallies only move on a commit, which needs an empty or draining result
    // register, so they match the held result for as long as it is shown.
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign gives_block      = gives_reg;
    assign result_block     = blk_reg;
    assign allocations_done = alloc_tally_reg;
    assign frees_done       = free_tally_reg;
    assign bytes_in_use     = byte_tally_reg;
    assign chunks_grown     = chunk_tally_reg;

endmodule

`default_nettype wire

@@ src/block_pool_free_list_allocator.sv @@
// Fixed-size block pool allocator, top level: controller plus datapath (bpfl_pkg).
// Timing: a request is captured in idle and the result register loads from execute, so
// out_valid rises when it loads; a held, unclaimed result delays the load.
// Requests: one at a time, captured and then executed, as set by the registered
// link store read at the list head; a stalled result keeps the block in execute.
// Reset (rst_n, async, active low): list empty, tallies zero, sizes 256/1024; store kept.
`timescale 1ns / 1ps
`default_nettype none

module block_pool_free_list_allocator
    import bpfl_pkg::*;
#(
    parameter int POOL_BLOCKS = 4096    // blocks the pool may grow to, 2 to 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration writes, to be issued only with no request in flight
    input  wire logic                  cfg_write,
    input  wire logic                  cfg_index,
    input  wire logic [BYTES_W-1:0]    cfg_data,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [SIZE_W-1:0]     request_size,
    input  wire logic                  has_block,
    input  wire logic [BLK_W-1:0]      block_index,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STAT_W-1:0]          status,
    output logic                       gives_block,
    output logic [BLK_W-1:0]           result_block,
    output logic [TALLY_W-1:0]         allocations_done,
    output logic [TALLY_W-1:0]         frees_done,
    output logic [BTALLY_W-1:0]        bytes_in_use,
    output logic [CHUNK_W-1:0]         chunks_grown
);

    bpfl_cmd_t  cmd;
    bpfl_stat_t stat;

    // Sequencer: idle (request stall low) -> execute (commit when the result
    // register can take the answer) -> idle.
    bpfl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: the link store read of the head is ready during execute, so a
    // pop takes its new head from the store and a push writes the old head
    // into the freed block's entry. Fresh indices come from a counter.
    bpfl_datapath #(
        .POOL_BLOCKS (POOL_BLOCKS)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .kind             (kind),
        .request_size     (request_size),
        .has_block        (has_block),
        .block_index      (block_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .gives_block      (gives_block),
        .result_block     (result_block),
        .allocations_done (allocations_done),
        .frees_done       (frees_done),
        .bytes_in_use     (bytes_in_use),
        .chunks_grown     (chunks_grown)
    );

    // One request at a time: an accepted request is never followed at once.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while the previous one executes");

    // A returned block always comes with an ok status.
    a_block_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && gives_block) |-> (status == STAT_OK))
        else $error("block returned with a failure status");

    // Chunk growth only happens when a result is loaded.
    a_growth_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(chunks_grown) |-> out_valid)
        else $error("chunk tally moved without a result");

endmodule

`default_nettype wire
